// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the word unit, the engine and the top level.
package bba_pkg;

	localparam int WORD_BITS = 32;   // blocks per bitmap word
	localparam int WORD_LW   = 5;    // bits of a position inside a word
	localparam int BLK_W     = 11;   // block numbers and counts
	localparam int IDX_W     = 10;   // block_index and result_block
	localparam int TYPE_W    = 3;
	localparam int ADDR_W    = 32;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [BLK_W-1:0] TOTAL_RESET = 11'd1024;

	// Register select taken from paddr[2].
	localparam logic REG_TOTAL = 1'b0;

	typedef enum logic [TYPE_W-1:0] {
		REQ_INIT    = 3'd0,
		REQ_REGION  = 3'd1,
		REQ_NEXT    = 3'd2,
		REQ_RESERVE = 3'd3,
		REQ_FREE    = 3'd4,
		REQ_STATUS  = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		WU_READ = 2'd0,
		WU_SET  = 2'd1,
		WU_CLR  = 2'd2,
		WU_SCAN = 2'd3
	} wu_op_t;

	typedef struct packed {
		wu_op_t             op;
		logic [WORD_LW-1:0] lo;   // first bit of the window
		logic [WORD_LW:0]   hi;   // one past the last bit, 1 to 32
	} wu_ctl_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 found;
		logic [WORD_LW-1:0]   pos;
		logic                 hit;
	} wu_res_t;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [IDX_W-1:0]  block_index;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
	} bba_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_block;
		logic             failed;
		logic             block_used;
		logic [BLK_W-1:0] used_count;
	} bba_res_t;

	typedef struct packed {
		logic ready;
		logic done;
	} eng_stat_t;

endpackage

// ===== hw/rtl/bba_word_unit.sv =====
// Shared word unit: sets, clears, reads or scans a bit window of one bitmap word.
// Depends on bba_pkg.
module bba_word_unit
	import bba_pkg::*;
(
	input  logic [WORD_BITS-1:0] word,
	input  wu_ctl_t              ctl,
	output wu_res_t              res
);

	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lowest;
	logic [WORD_LW-1:0]   pos;

	always_comb begin
		lo_mask   = ~((32'd1 << ctl.lo) - 32'd1);
		hi_mask   = ctl.hi[WORD_LW] ? '1 : ((32'd1 << ctl.hi[WORD_LW-1:0]) - 32'd1);
		mask      = lo_mask & hi_mask;
		free_bits = ~word & mask;
		// Isolate the lowest free bit of the window.
		lowest    = free_bits & (~free_bits + 32'd1);
		pos       = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			pos = pos | (lowest[i] ? WORD_LW'(i) : '0);
		end
		res.found = |free_bits;
		res.hit   = |(word & mask);
		res.pos   = pos;
		unique case (ctl.op)
			WU_SET:  res.word = word | mask;
			WU_CLR:  res.word = word & ~mask;
			WU_SCAN: res.word = word | lowest;
			default: res.word = word;
		endcase
	end

endmodule

// ===== hw/rtl/bba_engine.sv =====
// Request sequencer with the bitmap memory and the used-block counter.
// Depends on bba_pkg and bba_word_unit.
module bba_engine
	import bba_pkg::*;
#(
	parameter int BLOCK_BYTES = 4096,
	parameter int MAX_BLOCKS  = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bba_req_t         req,
	input  logic [BLK_W-1:0] total,
	output eng_stat_t        stat,
	output bba_res_t         res
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SH        = $clog2(BLOCK_BYTES);
	localparam int FW        = ADDR_W - SH;
	localparam int RST_CNT   = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REG2,
		S_READ,
		S_EVAL
	} state_t;

	state_t               state_q;
	req_type_t            req_q;
	logic [WAW-1:0]       w_q;
	logic [BLK_W-1:0]     blk_lo_q;
	logic [BLK_W-1:0]     blk_hi_q;
	logic [FW-1:0]        first_q;
	logic [ADDR_W-1:0]    len_q;
	logic [BLK_W-1:0]     count_q;
	logic                 reply_q;
	logic                 done_q;
	logic [IDX_W-1:0]     res_block_q;
	logic                 failed_q;
	logic                 used_q;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	req_type_t            start_type;
	wu_ctl_t              ctl;
	wu_res_t              wu;
	logic [WAW-1:0]       lo_word;
	logic [WAW-1:0]       hi_word;
	logic                 last_word;
	logic [WORD_LW:0]     k;
	logic [BLK_W-1:0]     cnt_dec;
	logic [BLK_W-1:0]     cnt_inc;
	logic [ADDR_W:0]      stop_sum;
	logic [BLK_W-1:0]     stop;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;

	bba_word_unit u_word_unit (
		.word (rdata_q),
		.ctl  (ctl),
		.res  (wu)
	);

	always_comb begin
		start_type = req_type_t'(req.req_type);
		lo_word    = WAW'(blk_lo_q >> WORD_LW);
		hi_word    = WAW'(blk_hi_q >> WORD_LW);
		last_word  = (w_q == hi_word);
		ctl.lo     = (w_q == lo_word) ? blk_lo_q[WORD_LW-1:0] : '0;
		ctl.hi     = last_word ? ({1'b0, blk_hi_q[WORD_LW-1:0]} + 6'd1) : 6'd32;
		k          = ctl.hi - {1'b0, ctl.lo};
		unique case (req_q)
			REQ_NEXT:    ctl.op = WU_SCAN;
			REQ_RESERVE: ctl.op = WU_SET;
			REQ_REGION,
			REQ_FREE:    ctl.op = WU_CLR;
			default:     ctl.op = WU_READ;
		endcase
		// The count moves per block and saturates at zero and at the total.
		cnt_dec = (count_q > BLK_W'(k)) ? (count_q - BLK_W'(k)) : '0;
		cnt_inc = (count_q < total) ? (count_q + 11'd1) : count_q;
		// End of the region in blocks, with a partial block rounded up.
		stop_sum = (ADDR_W+1)'(first_q) + (ADDR_W+1)'(len_q >> SH)
			+ (ADDR_W+1)'(|len_q[SH-1:0]);
		stop     = (stop_sum < (ADDR_W+1)'(total)) ? BLK_W'(stop_sum) : total;
		we       = (state_q == S_CLEAR)
			|| ((state_q == S_EVAL) && (req_q != REQ_STATUS));
		wdata    = (state_q == S_CLEAR) ? '1 : wu.word;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[w_q] <= wdata;
		end
		if (state_q == S_READ) begin
			rdata_q <= mem[w_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			req_q       <= REQ_INIT;
			w_q         <= '0;
			blk_lo_q    <= '0;
			blk_hi_q    <= '0;
			first_q     <= '0;
			len_q       <= '0;
			count_q     <= BLK_W'(RST_CNT);
			reply_q     <= 1'b0;
			done_q      <= 1'b0;
			res_block_q <= '0;
			failed_q    <= 1'b0;
			used_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (w_q == LAST_WORD) begin
						state_q <= S_IDLE;
						done_q  <= reply_q;
						reply_q <= 1'b0;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q       <= start_type;
						res_block_q <= req.block_index;
						failed_q    <= 1'b0;
						used_q      <= 1'b0;
						unique case (start_type)
							REQ_INIT: begin
								count_q <= total;
								w_q     <= '0;
								reply_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							REQ_REGION: begin
								len_q   <= req.end_addr - req.start_addr;
								first_q <= FW'(req.start_addr >> SH);
								state_q <= S_REG2;
							end
							REQ_NEXT: begin
								if (total == '0) begin
									failed_q    <= 1'b1;
									res_block_q <= '0;
									done_q      <= 1'b1;
								end else begin
									blk_lo_q <= '0;
									blk_hi_q <= total - 11'd1;
									w_q      <= '0;
									state_q  <= S_READ;
								end
							end
							REQ_RESERVE,
							REQ_FREE,
							REQ_STATUS: begin
								if (BLK_W'(req.block_index) < total) begin
									blk_lo_q <= BLK_W'(req.block_index);
									blk_hi_q <= BLK_W'(req.block_index);
									w_q      <= WAW'(req.block_index >> WORD_LW);
									state_q  <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_REG2: begin
					if ((ADDR_W+1)'(first_q) >= (ADDR_W+1)'(stop)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						blk_lo_q <= BLK_W'(first_q);
						blk_hi_q <= stop - 11'd1;
						w_q      <= WAW'(first_q >> WORD_LW);
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					unique case (req_q)
						REQ_NEXT: begin
							if (wu.found) begin
								count_q     <= cnt_inc;
								res_block_q <= IDX_W'({w_q, wu.pos});
							end else if (last_word) begin
								failed_q    <= 1'b1;
								res_block_q <= '0;
							end else begin
								w_q     <= w_q + 1'b1;
								state_q <= S_READ;
								done_q  <= 1'b0;
							end
						end
						REQ_REGION: begin
							count_q <= cnt_dec;
							if (!last_word) begin
								w_q     <= w_q + 1'b1;
								state_q <= S_READ;
								done_q  <= 1'b0;
							end
						end
						REQ_FREE:    count_q <= cnt_dec;
						REQ_RESERVE: count_q <= cnt_inc;
						REQ_STATUS:  used_q  <= wu.hit;
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.ready       = (state_q == S_IDLE) && !done_q;
	assign stat.done        = done_q;
	assign res.result_block = res_block_q;
	assign res.failed       = failed_q;
	assign res.block_used   = used_q;
	assign res.used_count   = count_q;

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: configuration port, handshakes, engine.
// Depends on bba_pkg and bba_engine.
//
// The block keeps one used bit per BLOCK_BYTES-sized block, MAX_BLOCKS bits in
// a single-port style memory of 32-bit words, and a count of used blocks that
// moves on every set or clear and saturates at zero and at the total. It works
// on one transaction at a time and returns exactly one result transaction per
// request; a new request is taken only after the previous result has been
// taken. Each visit of a bitmap word is one memory read followed by one pass
// through the shared word unit: reserve, free and status visit at most one
// word, reserve-next visits each word it scans, add-region visits each word
// it touches after a setup step, and init rewrites the whole memory.
// After reset a clearing pass writes every word to all ones (32 words with
// the default parameters), during which no request transaction is accepted;
// configuration writes are taken at any time. BLOCK_BYTES must be a power of
// two. The total_blocks register sits at byte address 0.
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int BLOCK_BYTES = 4096,
	parameter int MAX_BLOCKS  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Request channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TYPE_W-1:0]  req_type,
	input  logic [IDX_W-1:0]   block_index,
	input  logic [ADDR_W-1:0]  start_addr,
	input  logic [ADDR_W-1:0]  end_addr,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   result_block,
	output logic               failed,
	output logic               block_used,
	output logic [BLK_W-1:0]   used_count
);

	// Largest total the engine ever sees, the smaller of the register range
	// and the bitmap size.
	localparam int MAXC = (MAX_BLOCKS < 2047) ? MAX_BLOCKS : 2047;

	logic [BLK_W-1:0] total_q;
	logic [BLK_W-1:0] eff_total;
	logic             out_valid_q;
	logic             start;
	bba_req_t         req;
	bba_res_t         res;
	eng_stat_t        stat;

	// The register takes its new value at the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TOTAL)) begin
			total_q <= pwdata[BLK_W-1:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_TOTAL) ? PDATA_W'(total_q) : '0;
	assign eff_total = (total_q < BLK_W'(MAXC)) ? total_q : BLK_W'(MAXC);

	// A request is held off while the engine works and while a result waits.
	assign in_stall = !stat.ready || out_valid_q;
	assign start    = in_valid && !in_stall;

	assign req.req_type    = req_type;
	assign req.block_index = block_index;
	assign req.start_addr  = start_addr;
	assign req.end_addr    = end_addr;

	bba_engine #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.MAX_BLOCKS  (MAX_BLOCKS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.total  (eff_total),
		.stat   (stat),
		.res    (res)
	);

	// The engine's result registers hold still until the next request, so
	// only the valid flag lives here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_block = res.result_block;
	assign failed       = res.failed;
	assign block_used   = res.block_used;
	assign used_count   = res.used_count;

endmodule

// ===== hw/rtl/bba_checker.sv =====
// Port-level assertions for the bitmap block allocator and their bind.
// Depends on the port list of bitmap_block_allocator.
module bba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [9:0]  result_block,
	input logic        failed,
	input logic        block_used,
	input logic [10:0] used_count
);

	// No new request is taken while a result waits.
	a_stall_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while a result is pending");

	// An accepted request leaves the block busy, with no result shown, in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("block not busy right after a request");

	// A failed reserve-next reports block zero and no status bit.
	a_failed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> ((result_block == 10'd0) && !block_used))
		else $error("failed result carries stray fields");

	// One result per request: a taken result is not shown again.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated after it was taken");

	// A stalled result holds its payload.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(result_block) && $stable(used_count)))
		else $error("stalled result changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
